@@ sv/pva_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pva_pkg
// Shared types and constants for the polyphonic voice allocator.
// ============================================================================
package pva_pkg;

    localparam int NOTE_COUNT     = 128;
    localparam int NOTE_W         = 7;
    localparam int VOICE_FIELD_W  = 3;
    localparam int VOICES_DEFAULT = 8;

    localparam logic [NOTE_W-1:0] NOTE_LAST = NOTE_W'(NOTE_COUNT - 1);

    typedef enum logic [1:0] {
        REQ_NOTE_START  = 2'd0,
        REQ_NOTE_STOP   = 2'd1,
        REQ_RELEASE_ALL = 2'd2,
        REQ_VOICE_DONE  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ACT_NONE        = 2'd0,
        ACT_START       = 2'd1,
        ACT_RELEASE     = 2'd2,
        ACT_RELEASE_ALL = 2'd3
    } t_action;

    typedef struct packed {
        t_req_type                req_type;
        logic [NOTE_W-1:0]        note;
        logic [VOICE_FIELD_W-1:0] voice_id;
    } t_request;

    typedef struct packed {
        t_action                  action;
        logic [VOICE_FIELD_W-1:0] voice;
        logic                     was_stolen;
        logic                     unmapped_valid;
        logic [NOTE_W-1:0]        unmapped_note;
        logic                     any_active;
    } t_result;

    // age list operations
    typedef enum logic [1:0] {
        ORD_NONE      = 2'd0,
        ORD_POP       = 2'd1,
        ORD_MOVE_BACK = 2'd2,
        ORD_APPEND    = 2'd3
    } t_order_op;

    // note map port controls
    typedef struct packed {
        logic [NOTE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NOTE_W-1:0] wr_addr;
        logic              clr_en;
        logic [NOTE_W-1:0] clr_addr;
        logic              clr_all;
    } t_map_ctrl;

endpackage

@@ sv/poly_voice_allocator_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// poly_voice_allocator_unit
// Voice allocator with oldest-voice stealing, run by a small sequencer.
// ============================================================================
// Release all and voice finished answer straight from idle; note stop goes
//   through the map lookup; note start adds commit and an age list walk, and
//   a map scan (one note entry per cycle) when a voice is stolen.
// Throughput: one request at a time; busy drops in the result strobe cycle.
//   The 128-entry map scan sets the worst case; the strobe cannot be stalled.
// Reset (synchronous, active low) empties map, active flags and age list.
// ============================================================================
module poly_voice_allocator_unit #(
    parameter int VOICES = pva_pkg::VOICES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pva_pkg::t_request i_request,
    output logic              o_result_strobe,
    output pva_pkg::t_result  o_result
);
    import pva_pkg::*;

    localparam int PW = $clog2(VOICES);       // voice index width
    localparam int CW = $clog2(VOICES + 1);   // list count width

    // one-hot sequencer
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,   // map lookup result is in
        S_SCAN   = 5'b00100,   // steal: find lowest note held by the victim
        S_COMMIT = 5'b01000,   // write map, mark voice active
        S_FIND   = 5'b10000    // walk age list, move voice to newest end
    } t_state;

    t_state            r_state, n_state;
    t_request          r_req, n_req;
    logic [PW-1:0]     r_vi, n_vi;
    logic              r_stolen, n_stolen;
    logic              r_uvalid, n_uvalid;
    logic [NOTE_W-1:0] r_unote, n_unote;
    logic [NOTE_W-1:0] r_scan_addr, n_scan_addr;
    logic [NOTE_W-1:0] r_cmp_addr, n_cmp_addr;
    logic              r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]     r_pos, n_pos;
    logic [VOICES-1:0] r_active, n_active;
    t_result           r_result, n_result;
    logic              r_strobe, n_strobe;

    // map and age list hookups
    t_map_ctrl     map_ctrl;
    logic [PW-1:0] map_wr_data;
    logic [PW-1:0] map_rd_data;
    logic          map_rd_valid;
    t_order_op     ord_op;
    logic [PW-1:0] ord_head;
    logic [PW-1:0] ord_entry;
    logic [CW-1:0] ord_count;

    // lowest idle voice
    logic          idle_found;
    logic [PW-1:0] idle_vi;

    pva_map #(
        .VW(PW)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (map_ctrl),
        .i_wr_data  (map_wr_data),
        .o_rd_data  (map_rd_data),
        .o_rd_valid (map_rd_valid)
    );

    pva_order #(
        .VOICES(VOICES)
    ) u_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (ord_op),
        .i_pos   (r_pos[PW-1:0]),
        .i_voice (r_vi),
        .o_head  (ord_head),
        .o_entry (ord_entry),
        .o_count (ord_count)
    );

    always_comb begin
        idle_found = 1'b0;
        idle_vi    = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                idle_found = 1'b1;
                idle_vi    = PW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_vi        = r_vi;
        n_stolen    = r_stolen;
        n_uvalid    = r_uvalid;
        n_unote     = r_unote;
        n_scan_addr = r_scan_addr;
        n_cmp_addr  = r_cmp_addr;
        n_cmp_vld   = 1'b0;
        n_pos       = r_pos;
        n_active    = r_active;
        n_result    = r_result;
        n_strobe    = 1'b0;
        map_ctrl         = '0;
        map_ctrl.rd_addr = r_req.note;
        map_wr_data      = r_vi;
        ord_op           = ORD_NONE;

        case (r_state)
            S_IDLE: begin
                // lookup goes out on the accept edge
                map_ctrl.rd_addr = i_request.note;
                if (start) begin
                    n_req = i_request;
                    case (i_request.req_type)
                        REQ_NOTE_START, REQ_NOTE_STOP: begin
                            n_state = S_DECIDE;
                        end
                        REQ_RELEASE_ALL: begin
                            map_ctrl.clr_all    = 1'b1;
                            n_result            = '0;
                            n_result.action     = ACT_RELEASE_ALL;
                            n_result.any_active = |r_active;
                            n_strobe            = 1'b1;
                        end
                        default: begin
                            // voice finished; out-of-range ids match nothing
                            for (int i = 0; i < VOICES; i++) begin
                                if (int'(i_request.voice_id) == i) begin
                                    n_active[i] = 1'b0;
                                end
                            end
                            n_result            = '0;
                            n_result.action     = ACT_NONE;
                            n_result.any_active = |n_active;
                            n_strobe            = 1'b1;
                        end
                    endcase
                end
            end

            S_DECIDE: begin
                case (r_req.req_type)
                    REQ_NOTE_STOP: begin
                        n_result = '0;
                        if (map_rd_valid) begin
                            map_ctrl.clr_en   = 1'b1;
                            map_ctrl.clr_addr = r_req.note;
                            n_result.action   = ACT_RELEASE;
                            n_result.voice    = VOICE_FIELD_W'(map_rd_data);
                        end else begin
                            n_result.action   = ACT_NONE;
                        end
                        n_result.any_active = |r_active;
                        n_strobe            = 1'b1;
                        n_state             = S_IDLE;
                    end
                    default: begin
                        // note start
                        n_stolen = 1'b0;
                        n_uvalid = 1'b0;
                        n_unote  = '0;
                        n_pos    = '0;
                        if (map_rd_valid) begin
                            n_vi    = map_rd_data;      // held note: same voice
                            n_state = S_COMMIT;
                        end else if (idle_found) begin
                            n_vi    = idle_vi;
                            n_state = S_COMMIT;
                        end else if (ord_count != '0) begin
                            n_vi        = ord_head;     // steal the oldest
                            ord_op      = ORD_POP;
                            n_stolen    = 1'b1;
                            n_scan_addr = '0;
                            n_state     = S_SCAN;
                        end else begin
                            n_vi    = '0;
                            n_state = S_COMMIT;
                        end
                    end
                endcase
            end

            S_SCAN: begin
                // read one entry per cycle, compare the one read last cycle
                map_ctrl.rd_addr = r_scan_addr;
                n_scan_addr      = r_scan_addr + NOTE_W'(1);
                n_cmp_addr       = r_scan_addr;
                n_cmp_vld        = 1'b1;
                if (r_cmp_vld) begin
                    if (map_rd_valid && map_rd_data == r_vi) begin
                        map_ctrl.clr_en   = 1'b1;
                        map_ctrl.clr_addr = r_cmp_addr;
                        n_uvalid          = 1'b1;
                        n_unote           = r_cmp_addr;
                        n_state           = S_COMMIT;
                    end else if (r_cmp_addr == NOTE_LAST) begin
                        n_state = S_COMMIT;
                    end
                end
            end

            S_COMMIT: begin
                map_ctrl.wr_en   = 1'b1;
                map_ctrl.wr_addr = r_req.note;
                map_wr_data      = r_vi;
                n_active[r_vi]   = 1'b1;
                n_pos            = '0;
                n_state          = S_FIND;
            end

            S_FIND: begin
                if (r_pos == ord_count || ord_entry == r_vi) begin
                    if (r_pos == ord_count) begin
                        if (ord_count < CW'(VOICES)) begin
                            ord_op = ORD_APPEND;
                        end
                    end else begin
                        ord_op = ORD_MOVE_BACK;
                    end
                    n_result.action         = ACT_START;
                    n_result.voice          = VOICE_FIELD_W'(r_vi);
                    n_result.was_stolen     = r_stolen;
                    n_result.unmapped_valid = r_uvalid;
                    n_result.unmapped_note  = r_unote;
                    n_result.any_active     = |r_active;
                    n_strobe                = 1'b1;
                    n_state                 = S_IDLE;
                end else begin
                    n_pos = r_pos + CW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_strobe  <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_strobe  <= n_strobe;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_vi        <= n_vi;
        r_stolen    <= n_stolen;
        r_uvalid    <= n_uvalid;
        r_unote     <= n_unote;
        r_scan_addr <= n_scan_addr;
        r_cmp_addr  <= n_cmp_addr;
        r_pos       <= n_pos;
        r_result    <= n_result;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

@@ sv/pva_map.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pva_map
// Note-to-voice map: RAM for voice numbers, per-note valid flops.
// ============================================================================
module pva_map #(
    parameter int VW = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pva_pkg::t_map_ctrl   i_ctrl,
    input  logic [VW-1:0]        i_wr_data,
    output logic [VW-1:0]        o_rd_data,
    output logic                 o_rd_valid
);
    import pva_pkg::*;

    logic [VW-1:0]         r_mem [NOTE_COUNT];
    logic [NOTE_COUNT-1:0] r_valid;
    logic [VW-1:0]         r_rd_data;
    logic                  r_rd_valid;

    // registered read, single write port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_ctrl.rd_addr];
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_ctrl.rd_addr];
            if (i_ctrl.clr_all) begin
                r_valid <= '0;
            end else begin
                if (i_ctrl.wr_en) begin
                    r_valid[i_ctrl.wr_addr] <= 1'b1;
                end
                if (i_ctrl.clr_en) begin
                    r_valid[i_ctrl.clr_addr] <= 1'b0;
                end
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

@@ sv/pva_order.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pva_order
// Age list of voices, oldest at position zero.
// ============================================================================
module pva_order #(
    parameter  int VOICES = pva_pkg::VOICES_DEFAULT,
    localparam int PW     = $clog2(VOICES),
    localparam int CW     = $clog2(VOICES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pva_pkg::t_order_op  i_op,
    input  logic [PW-1:0]       i_pos,
    input  logic [PW-1:0]       i_voice,
    output logic [PW-1:0]       o_head,
    output logic [PW-1:0]       o_entry,
    output logic [CW-1:0]       o_count
);
    import pva_pkg::*;

    logic [PW-1:0] r_list [VOICES];
    logic [PW-1:0] n_list [VOICES];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    always_comb begin
        n_list  = r_list;
        n_count = r_count;
        case (i_op)
            ORD_POP: begin
                for (int i = 0; i < VOICES; i++) begin
                    n_list[i] = r_list[(i + 1) % VOICES];
                end
                n_count = r_count - CW'(1);
            end
            ORD_MOVE_BACK: begin
                // close the gap at i_pos, voice goes to the newest slot
                for (int i = 0; i < VOICES; i++) begin
                    if (CW'(i) >= CW'(i_pos) && CW'(i + 1) < r_count) begin
                        n_list[i] = r_list[(i + 1) % VOICES];
                    end else if (CW'(i + 1) == r_count) begin
                        n_list[i] = i_voice;
                    end
                end
            end
            ORD_APPEND: begin
                for (int i = 0; i < VOICES; i++) begin
                    if (CW'(i) == r_count) begin
                        n_list[i] = i_voice;
                    end
                end
                n_count = r_count + CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_list <= n_list;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = r_list[0];
    assign o_entry = r_list[i_pos];
    assign o_count = r_count;

endmodule

@@ sv/pva_check.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pva_check
// Port-level checks for the voice allocator, bound to the top level.
// ============================================================================
module pva_check (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              i_busy,
    input logic              i_result_strobe,
    input pva_pkg::t_result  i_result
);
    import pva_pkg::*;

    // a result only appears once the sequencer is back to ready
    a_strobe_not_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_result_strobe |-> !i_busy
    ) else $error("result strobe while busy");

    // every accepted request either starts work or answers at once
    a_accept_progress: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> (i_busy || i_result_strobe)
    ) else $error("accepted request produced neither work nor result");

    // release all carries no voice and no steal information
    a_release_all_clean: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_result_strobe && i_result.action == ACT_RELEASE_ALL) |->
            (i_result.voice == '0 && !i_result.was_stolen && !i_result.unmapped_valid)
    ) else $error("release all result carries voice data");

    // a cleared mapping only comes from a steal on a started voice
    a_unmap_from_steal: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_result_strobe && i_result.unmapped_valid) |->
            (i_result.was_stolen && i_result.action == ACT_START)
    ) else $error("unmapped note without a steal");

    // a started voice is active afterwards
    a_start_active: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_result_strobe && i_result.action == ACT_START) |-> i_result.any_active
    ) else $error("voice started but none active");

endmodule

bind poly_voice_allocator_unit pva_check u_pva_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (start),
    .i_busy          (busy),
    .i_result_strobe (o_result_strobe),
    .i_result        (o_result)
);

@@ verif/pva_allocation_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pva_allocation_checker
// Watches the request and result channels of the voice allocator, predicts
// each result from its own copy of the note map, active flags and age list,
// and compares every strobed result field by field with the oldest
// prediction.
// ============================================================================
module pva_allocation_checker #(
    parameter int VOICES = pva_pkg::VOICES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  pva_pkg::t_request i_request,
    input  logic              i_result_strobe,
    input  pva_pkg::t_result  i_result,
    output int                o_fail_count,
    output int                o_outstanding
);
    import pva_pkg::*;

    localparam int OWNER_W = $clog2(VOICES + 1);
    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    // note_owner: 0 = unmapped, else voice + 1
    logic [OWNER_W-1:0] note_owner [NOTE_COUNT];
    logic [VOICES-1:0]  voice_sounding;
    logic [VOICE_W-1:0] age_list [VOICES];
    int                 age_len;

    t_result expected_results [$];

    function automatic void drop_age_entry(input int pos);
        for (int i = pos; i + 1 < age_len; i++) begin
            age_list[i] = age_list[i + 1];
        end
        if (age_len > 0) begin
            age_len--;
        end
    endfunction

    function automatic t_result allocate_voice(input t_request r);
        t_result res;
        int      v;
        bit      found;
        res = '0;
        case (r.req_type)
            REQ_NOTE_START: begin
                if (note_owner[r.note] != 0) begin
                    v = int'(note_owner[r.note]) - 1;
                end else begin
                    found = 1'b0;
                    v     = 0;
                    for (int i = 0; i < VOICES; i++) begin
                        if (!found && !voice_sounding[i]) begin
                            v     = i;
                            found = 1'b1;
                        end
                    end
                    // all voices busy: steal the oldest, unmap its lowest note
                    if (!found && age_len > 0) begin
                        v = int'(age_list[0]);
                        drop_age_entry(0);
                        res.was_stolen = 1'b1;
                        for (int n = 0; n < NOTE_COUNT; n++) begin
                            if (!res.unmapped_valid && note_owner[n] == OWNER_W'(v + 1)) begin
                                note_owner[n]      = '0;
                                res.unmapped_valid = 1'b1;
                                res.unmapped_note  = NOTE_W'(n);
                            end
                        end
                    end
                end
                voice_sounding[v]  = 1'b1;
                note_owner[r.note] = OWNER_W'(v + 1);
                found = 1'b0;
                for (int i = 0; i < VOICES; i++) begin
                    if (!found && i < age_len && int'(age_list[i]) == v) begin
                        drop_age_entry(i);
                        found = 1'b1;
                    end
                end
                if (age_len < VOICES) begin
                    age_list[age_len] = VOICE_W'(v);
                    age_len++;
                end
                res.action = ACT_START;
                res.voice  = VOICE_FIELD_W'(v);
            end
            REQ_NOTE_STOP: begin
                if (note_owner[r.note] != 0) begin
                    res.voice          = VOICE_FIELD_W'(int'(note_owner[r.note]) - 1);
                    note_owner[r.note] = '0;
                    res.action         = ACT_RELEASE;
                end
            end
            REQ_RELEASE_ALL: begin
                for (int n = 0; n < NOTE_COUNT; n++) begin
                    note_owner[n] = '0;
                end
                res.action = ACT_RELEASE_ALL;
            end
            default: begin
                if (int'(r.voice_id) < VOICES) begin
                    voice_sounding[r.voice_id] = 1'b0;
                end
            end
        endcase
        res.any_active = |voice_sounding;
        return res;
    endfunction

    function automatic void check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            o_fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp;
        if (!i_rst_n) begin
            for (int n = 0; n < NOTE_COUNT; n++) begin
                note_owner[n] = '0;
            end
            voice_sounding = '0;
            age_len        = 0;
            expected_results.delete();
            o_fail_count   = 0;
        end else begin
            if (i_result_strobe) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result: expected none, actual %p",
                             $time, i_result);
                end else begin
                    exp = expected_results.pop_front();
                    check_field("action", exp.action, i_result.action);
                    check_field("voice", exp.voice, i_result.voice);
                    check_field("was_stolen", exp.was_stolen, i_result.was_stolen);
                    check_field("unmapped_valid", exp.unmapped_valid,
                                i_result.unmapped_valid);
                    check_field("unmapped_note", exp.unmapped_note, i_result.unmapped_note);
                    check_field("any_active", exp.any_active, i_result.any_active);
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(allocate_voice(i_request));
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

@@ verif/poly_voice_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// poly_voice_allocator_unit_tb
// Drives note start/stop, release-all and voice-finished requests into the
// allocator: a directed opening that walks through reuse, stealing and the
// corner cases, then random traffic over a sliding window of notes. A
// checker beside the block predicts and compares every result.
// ============================================================================
module poly_voice_allocator_unit_tb;
    import pva_pkg::*;

    localparam int VOICES          = VOICES_DEFAULT;
    // Worst request is a steal, which adds a scan over the whole map.
    // The sender's gaps are short, so hitting this quiet limit means a hang.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Settle time after the last result, a bit over one worst-case request.
    localparam int DRAIN_CYCLES    = 150;
    localparam int RANDOM_REQUESTS = 1350;
    localparam int IDLE_PERCENT    = 22;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_request;
    logic     o_result_strobe;
    t_result  o_result;

    int   fail_count;
    int   outstanding;
    int   quiet_cycles = 0;
    logic idle_enable;

    poly_voice_allocator_unit #(
        .VOICES(VOICES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result)
    );

    // Predicts and compares; the top only makes stimulus and gives the verdict.
    pva_allocation_checker #(
        .VOICES(VOICES)
    ) alloc_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_request      (i_request),
        .i_result_strobe(o_result_strobe),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: any edge with no accepted request and no result counts as quiet.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_request make_request(input t_req_type kind,
                                              input logic [NOTE_W-1:0] note,
                                              input logic [VOICE_FIELD_W-1:0] vid);
        t_request r;
        r.req_type = kind;
        r.note     = note;
        r.voice_id = vid;
        return r;
    endfunction

    // Called at a falling edge. Optionally idles at random first, then holds the
    // request until an edge sees busy low, and returns at the next falling
    // edge. start stays high on return; the next call either replaces the
    // request or drops start, so a stale request is never offered again.
    task automatic issue_request(input t_request r);
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start     = 1'b1;
        i_request = r;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int                 pick;
        int                 note_base;
        logic [NOTE_W-1:0]  n;
        t_req_type          kind;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_request    = '0;
        idle_enable  = 1'b1;
        note_base    = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed opening ----
        // stop of a note nobody holds, and a finish on an idle voice
        issue_request(make_request(REQ_NOTE_STOP, 7'd5, 3'd0));
        issue_request(make_request(REQ_VOICE_DONE, 7'd0, 3'd7));
        // lowest and highest notes take voices 0 and 1
        issue_request(make_request(REQ_NOTE_START, 7'd0, 3'd0));
        issue_request(make_request(REQ_NOTE_START, NOTE_LAST, 3'd7));
        // held note restarted: same voice, moved to newest
        issue_request(make_request(REQ_NOTE_START, 7'd0, 3'd0));
        // voice 0 finishes but note 0 still maps to it; restart reuses it
        issue_request(make_request(REQ_VOICE_DONE, NOTE_LAST, 3'd0));
        issue_request(make_request(REQ_NOTE_START, 7'd0, 3'd5));
        // fill the remaining voices
        for (int k = 0; k < VOICES - 2; k++) begin
            issue_request(make_request(REQ_NOTE_START, NOTE_W'(10 + k), 3'd0));
        end
        // all busy: oldest voice (1) stolen, note 127 unmapped
        issue_request(make_request(REQ_NOTE_START, 7'd64, 3'd0));
        issue_request(make_request(REQ_NOTE_STOP, 7'd64, 3'd7));
        issue_request(make_request(REQ_NOTE_STOP, NOTE_LAST, 3'd0));
        // release all empties the map but leaves voices active, so the next
        // start steals a voice that has no note left to unmap
        issue_request(make_request(REQ_RELEASE_ALL, NOTE_LAST, 3'd7));
        issue_request(make_request(REQ_NOTE_START, 7'd100, 3'd0));
        // free two voices; the lower one is picked
        issue_request(make_request(REQ_VOICE_DONE, 7'd0, 3'd7));
        issue_request(make_request(REQ_VOICE_DONE, 7'd0, 3'd3));
        issue_request(make_request(REQ_NOTE_START, 7'd1, 3'd0));
        issue_request(make_request(REQ_NOTE_STOP, 7'd1, 3'd0));

        // ---- random traffic ----
        // Notes come mostly from a 16-wide window that moves every 100
        // requests, so restarts, stops of held notes and steals are common;
        // one in ten uses any note as noise. Idling is off for a long stretch.
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            idle_enable = (k < 500 || k >= 800);
            if (k % 100 == 0) begin
                note_base = $urandom_range(NOTE_COUNT - 16);
            end
            if ($urandom_range(9) == 0) begin
                n = NOTE_W'($urandom);
            end else begin
                n = NOTE_W'(note_base + $urandom_range(15));
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                kind = REQ_NOTE_START;
            end else if (pick < 75) begin
                kind = REQ_NOTE_STOP;
            end else if (pick < 94) begin
                kind = REQ_VOICE_DONE;
            end else begin
                kind = REQ_RELEASE_ALL;
            end
            issue_request(make_request(kind, n, VOICE_FIELD_W'($urandom)));
        end
        start = 1'b0;

        // ---- drain and verdict ----
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ poly_voice_allocator_unit.f @@
sv/pva_pkg.sv
sv/pva_map.sv
sv/pva_order.sv
sv/poly_voice_allocator_unit.sv
sv/pva_check.sv
verif/pva_allocation_checker.sv
verif/poly_voice_allocator_unit_tb.sv
